// ===== hw/rtl/ptos_pkg.sv =====
// Shared types, reset values and codes for the presence table statistics core.
// Used by every module under hw/rtl.
`timescale 1ns / 1ps
package ptos_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic signed [7:0]  RSSI_FLOOR_RST = -8'sd90;
    localparam logic        [31:0] LIFETIME_RST   = 32'd60000;
    localparam logic        [7:0]  SAT_COUNT_RST  = 8'd10;

    localparam logic signed [7:0]  STRONGEST_INIT = -8'sd100;
    localparam logic signed [11:0] MEAN_EMPTY     = -12'sd1600;
    localparam logic signed [15:0] PEAK_RST       = -16'sd25600;

    // peak = (7*peak + 768*strongest + 5 + 10*65536) / 10 - 65536
    // divide by ten as multiply by ceil(2^23 / 10) and shift by 23
    localparam int EMA_W = 22;
    localparam logic signed [EMA_W-1:0] EMA_KEEP   = 22'sd7;
    localparam logic signed [EMA_W-1:0] EMA_GAIN   = 22'sd768;
    localparam logic signed [EMA_W-1:0] EMA_OFFSET = 22'sd655365;
    localparam logic        [EMA_W-1:0] EMA_RECIP  = 22'd838861;
    localparam int                      EMA_SHIFT  = 23;
    localparam logic        [7:0]       OCC_SCALE  = 8'd200;

    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RSSI_FLOOR = 2'd0,
        CFG_LIFETIME   = 2'd1,
        CFG_SAT_COUNT  = 2'd2
    } cfg_index_t;

    localparam logic OP_OBSERVE  = 1'b0;
    localparam logic OP_SNAPSHOT = 1'b1;

    typedef struct packed {
        logic [31:0]       key;
        logic signed [7:0] rssi;
        logic [31:0]       stamp;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic evict;
        logic write;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/ptos_cell.sv =====
// One table slot: key, RSSI, last-seen stamp and a valid bit.
// Depends on ptos_pkg; chained into a ring by the top level.
`timescale 1ns / 1ps
module ptos_cell
    import ptos_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cell_ctrl_t  ctrl,
    input  logic        wr_sel,
    input  entry_t      wr_entry,
    input  logic [31:0] now_ms,
    input  logic [31:0] lifetime,
    input  entry_t      nbr_entry,
    input  logic        nbr_valid,
    output entry_t      entry_q,
    output logic        valid_q,
    output logic        match
);

    entry_t      entry_reg;
    logic        valid_reg;
    logic [31:0] age;
    logic        alive;

    assign age     = now_ms - entry_reg.stamp;
    assign alive   = age < lifetime;
    assign match   = valid_reg && (entry_reg.key == wr_entry.key);
    assign entry_q = entry_reg;
    assign valid_q = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= nbr_valid;
        end else if (ctrl.evict) begin
            valid_reg <= valid_reg && alive;
        end else if (ctrl.write && wr_sel) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            entry_reg <= nbr_entry;
        end else if (ctrl.write && wr_sel) begin
            entry_reg <= wr_entry;
        end
    end

endmodule

// ===== hw/rtl/ptos_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on ptos_pkg only for the common import style.
`timescale 1ns / 1ps
module ptos_divider
    import ptos_pkg::*;
#(
    parameter int DVW = 36,
    parameter int DSW = 12
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           busy,
    output logic           done,
    output logic [DVW-1:0] quotient
);

    localparam int CNTW = $clog2(DVW + 1);

    logic [DVW-1:0]  quo_reg;
    logic [DSW-1:0]  rem_reg;
    logic [DSW-1:0]  dsr_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DSW:0]    trial;
    logic            fits;

    assign trial    = {rem_reg, quo_reg[DVW-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(DVW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVW-2:0], fits};
            rem_reg <= fits ? DSW'(trial - {1'b0, dsr_reg}) : DSW'(trial);
        end
    end

endmodule

// ===== hw/rtl/ptos_isqrt.sv =====
// Integer square root, one result bit per cycle (digit by digit).
// Depends on ptos_pkg only for the common import style.
`timescale 1ns / 1ps
module ptos_isqrt
    import ptos_pkg::*;
#(
    parameter int RW = 18
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int CNTW = $clog2(RW + 1);

    logic [2*RW-1:0] x_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RW+3:0]   r2;
    logic [RW+3:0]   trial;
    logic            fits;

    assign r2    = {rem_reg, x_reg[2*RW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = r2 >= trial;
    assign done  = done_reg;
    assign root  = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= x_reg << 2;
            rem_reg  <= fits ? (RW+2)'(r2 - trial) : (RW+2)'(r2);
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

endmodule

// ===== hw/rtl/presence_table_occupancy_stats_core.sv =====
// Presence table with occupancy statistics: top level.
// Depends on ptos_pkg, ptos_cell, ptos_divider and ptos_isqrt.
//
// Usage:
//   s_ channel: one transfer per item. s_tuser = operation (0 observe, 1 snapshot).
//   In an observation every cell compares its key at once, and
//   a match is refreshed or the first free cell is filled; a full table drops it.
//   A snapshot evicts stale cells, rotates the ring of TABLE_DEPTH
//   cells once around so the head cell feeds the accumulators, then runs the
//   shared bit-serial divider for mean, variance and occupancy, the square root
//   (variance and root only with more than one device) and a reciprocal
//   multiply for the average (only with a device present).
//   s_tready is low while a snapshot is in work.
//   m_ channel: one result per snapshot, held in an output register until
//   taken; a stalled receiver holds only the end of the next snapshot.
//   cfg_ channel: always ready; write only while idle.
//   Reset (aresetn low, synchronous) clears all valid bits, the average
//   and the registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
module presence_table_occupancy_stats_core
    import ptos_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,  // address_key[31:0], signal_strength[39:32],
                                           // now_ms[71:40]
    input  logic                 s_tuser,  // operation[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,  // device_count[5:0], strongest_rssi[13:6],
                                           // mean_rssi_q4[25:14], rssi_spread_q4[36:26],
                                           // occupancy_index[43:37], smoothed_peak_q8[59:44],
                                           // seen_any[60], zero fill
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW   = 8 + CW;
    localparam int QW   = 15 + CW;
    localparam int PW   = 15 + 2 * CW;
    localparam int DVW  = PW + 8;
    localparam int DSW  = (2 * CW > 9) ? 2 * CW : 9;
    localparam int RW   = (DVW + 1) / 2;

    localparam int O_CNT  = 0;
    localparam int O_STR  = 6;
    localparam int O_MEAN = 14;
    localparam int O_SPR  = 26;
    localparam int O_OCC  = 37;
    localparam int O_PEAK = 44;
    localparam int O_SEEN = 60;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_EVICT  = 11'b00000000010,
        ST_ROTATE = 11'b00000000100,
        ST_PROD   = 11'b00000001000,
        ST_DIFF   = 11'b00000010000,
        ST_MEAN   = 11'b00000100000,
        ST_VAR    = 11'b00001000000,
        ST_SQRT   = 11'b00010000000,
        ST_OCC    = 11'b00100000000,
        ST_EMA    = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic signed [7:0] floor_reg;
    logic [31:0]       lifetime_reg;
    logic [7:0]        sat_reg;
    logic [31:0]       now_reg;

    logic signed [15:0] peak_reg;
    logic [IW-1:0]      cnt_reg;
    logic [CW-1:0]      n_reg;
    logic signed [SW-1:0] sum_reg;
    logic [QW-1:0]      sumsq_reg;
    logic signed [7:0]  max_reg;
    logic [PW-1:0]      nsq_reg;
    logic [PW-1:0]      s2_reg;
    logic [2*CW-1:0]    nn_reg;
    logic [PW-1:0]      v_reg;
    logic               mean_neg_reg;
    logic signed [11:0] mean_reg;
    logic [10:0]        spread_reg;
    logic [6:0]         occ_reg;
    logic [EMA_W-1:0]   ema_num_reg;

    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic [63:0]        m_data_next;

    logic               div_start_reg;
    logic [DVW-1:0]     div_a_reg;
    logic [DSW-1:0]     div_b_reg;
    logic               div_busy;
    logic               div_done;
    logic [DVW-1:0]     div_q;
    logic               sqrt_start_reg;
    logic               sqrt_done;
    logic [RW-1:0]      sqrt_root;

    entry_t             obs_entry;
    logic               obs_fire;
    logic               snap_fire;
    cell_ctrl_t         ctrl;
    entry_t             cell_q  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_v;
    logic [TABLE_DEPTH-1:0] cell_m;
    logic [TABLE_DEPTH-1:0] wr_sel;
    logic [TABLE_DEPTH-1:0] first_free;

    logic signed [15:0]   head_sq;
    logic signed [SW+3:0] mean_num;
    logic [SW+3:0]        mean_mag;
    logic signed [PW:0]   v_diff;
    logic [8:0]           sat_eff;
    logic [8:0]           occ_m;
    logic [15:0]          occ_num;
    logic signed [EMA_W-1:0] ema_num;
    logic [2*EMA_W-1:0]   ema_prod;

    assign obs_entry.key   = s_tdata[31:0];
    assign obs_entry.rssi  = s_tdata[39:32];
    assign obs_entry.stamp = s_tdata[71:40];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign obs_fire  = s_tvalid && s_tready && (s_tuser == OP_OBSERVE)
                       && !(obs_entry.rssi < floor_reg);
    assign snap_fire = s_tvalid && s_tready && (s_tuser == OP_SNAPSHOT);

    assign ctrl.write = obs_fire;
    assign ctrl.evict = (state_reg == ST_EVICT);
    assign ctrl.shift = (state_reg == ST_ROTATE);

    always_comb begin
        logic taken;
        taken = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            first_free[i] = !cell_v[i] && !taken;
            taken         = taken || !cell_v[i];
        end
        wr_sel = (|cell_m) ? cell_m : first_free;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ptos_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .wr_sel    (wr_sel[g]),
            .wr_entry  (obs_entry),
            .now_ms    (now_reg),
            .lifetime  (lifetime_reg),
            .nbr_entry (cell_q[(g + 1) % TABLE_DEPTH]),
            .nbr_valid (cell_v[(g + 1) % TABLE_DEPTH]),
            .entry_q   (cell_q[g]),
            .valid_q   (cell_v[g]),
            .match     (cell_m[g])
        );
    end

    ptos_divider #(.DVW(DVW), .DSW(DSW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    ptos_isqrt #(.RW(RW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start_reg),
        .radicand ((2*RW)'(div_q)),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign head_sq  = cell_q[0].rssi * cell_q[0].rssi;
    assign mean_num = (SW+4)'(sum_reg) <<< 4;
    assign mean_mag = mean_num[SW+3] ? (SW+4)'(-mean_num) : (SW+4)'(mean_num);
    assign v_diff   = $signed({1'b0, nsq_reg}) - $signed({1'b0, s2_reg});
    assign sat_eff  = (sat_reg == 8'd0) ? 9'd1 : {1'b0, sat_reg};
    assign occ_m    = (9'(n_reg) < sat_eff) ? 9'(n_reg) : sat_eff;
    assign occ_num  = 16'(occ_m) * 16'(OCC_SCALE) + 16'(sat_eff);
    assign ema_num  = EMA_W'(peak_reg) * EMA_KEEP + EMA_W'(max_reg) * EMA_GAIN + EMA_OFFSET;
    assign ema_prod = (2*EMA_W)'(ema_num_reg) * (2*EMA_W)'(EMA_RECIP);

    always_comb begin
        m_data_next               = '0;
        m_data_next[O_CNT +: 6]   = 6'(n_reg);
        m_data_next[O_STR +: 8]   = max_reg;
        m_data_next[O_MEAN +: 12] = mean_reg;
        m_data_next[O_SPR +: 11]  = spread_reg;
        m_data_next[O_OCC +: 7]   = occ_reg;
        m_data_next[O_PEAK +: 16] = peak_reg;
        m_data_next[O_SEEN]       = (n_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg    <= RSSI_FLOOR_RST;
            lifetime_reg <= LIFETIME_RST;
            sat_reg      <= SAT_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RSSI_FLOOR: floor_reg    <= cfg_data[7:0];
                CFG_LIFETIME:   lifetime_reg <= cfg_data;
                CFG_SAT_COUNT:  sat_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            peak_reg       <= PEAK_RST;
            m_valid_reg    <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
        end else begin
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (snap_fire) begin
                        state_reg <= ST_EVICT;
                    end
                end
                ST_EVICT: state_reg <= ST_ROTATE;
                ST_ROTATE: begin
                    if (cnt_reg == IW'(TABLE_DEPTH - 1)) begin
                        state_reg <= ST_PROD;
                    end
                end
                ST_PROD: state_reg <= ST_DIFF;
                ST_DIFF: begin
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_MEAN;
                end
                ST_MEAN: begin
                    if (div_done) begin
                        div_start_reg <= 1'b1;
                        state_reg     <= (n_reg > CW'(1)) ? ST_VAR : ST_OCC;
                    end
                end
                ST_VAR: begin
                    if (div_done) begin
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_OCC;
                    end
                end
                ST_OCC: begin
                    if (div_done) begin
                        state_reg <= (n_reg != '0) ? ST_EMA : ST_OUT;
                    end
                end
                ST_EMA: begin
                    peak_reg  <= ema_prod[EMA_SHIFT +: 16];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                now_reg <= obs_entry.stamp;
            end
            ST_EVICT: begin
                cnt_reg    <= '0;
                n_reg      <= '0;
                sum_reg    <= '0;
                sumsq_reg  <= '0;
                max_reg    <= STRONGEST_INIT;
                spread_reg <= '0;
            end
            ST_ROTATE: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cell_v[0]) begin
                    n_reg     <= n_reg + 1'b1;
                    sum_reg   <= sum_reg + SW'(cell_q[0].rssi);
                    sumsq_reg <= sumsq_reg + QW'(head_sq[14:0]);
                    if (cell_q[0].rssi > max_reg) begin
                        max_reg <= cell_q[0].rssi;
                    end
                end
            end
            ST_PROD: begin
                nsq_reg <= PW'(n_reg) * PW'(sumsq_reg);
                s2_reg  <= PW'(sum_reg * sum_reg);
                nn_reg  <= (2*CW)'(n_reg) * (2*CW)'(n_reg);
            end
            ST_DIFF: begin
                v_reg        <= v_diff[PW] ? '0 : v_diff[PW-1:0];
                mean_neg_reg <= mean_num[SW+3];
                div_a_reg    <= DVW'(mean_mag);
                div_b_reg    <= (n_reg == '0) ? DSW'(1) : DSW'(n_reg);
            end
            ST_MEAN: begin
                if (div_done) begin
                    if (n_reg == '0) begin
                        mean_reg <= MEAN_EMPTY;
                    end else begin
                        mean_reg <= mean_neg_reg ? 12'(-div_q) : 12'(div_q);
                    end
                    if (n_reg > CW'(1)) begin
                        div_a_reg <= DVW'(v_reg) << 8;
                        div_b_reg <= DSW'(nn_reg);
                    end else begin
                        div_a_reg <= DVW'(occ_num);
                        div_b_reg <= DSW'({sat_eff, 1'b0});
                    end
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    spread_reg <= 11'(sqrt_root);
                    div_a_reg  <= DVW'(occ_num);
                    div_b_reg  <= DSW'({sat_eff, 1'b0});
                end
            end
            ST_OCC: begin
                if (div_done) begin
                    occ_reg     <= 7'(div_q);
                    ema_num_reg <= $unsigned(ema_num);
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= m_data_next;
                end
            end
            default: ;
        endcase
    end

    a_div_idle_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_busy)
        else $error("divider started while busy");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[O_OCC +: 7] <= 7'd100))
        else $error("occupancy above 100");

    a_seen_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[O_SEEN] == (m_tdata[O_CNT +: 6] != 6'd0)))
        else $error("seen_any disagrees with device_count");

    a_snapshot_evicts: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_fire |=> (state_reg == ST_EVICT))
        else $error("snapshot did not start with eviction");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for presence_table_occupancy_stats_core.
// Drives observations and snapshot requests over the stream ports and compares each snapshot
// against an in-bench model of the table; depends on ptos_pkg and the RTL only.
`timescale 1ns / 1ps
module tb;
    import ptos_pkg::*;

    localparam int DEPTH = 32;
    localparam int DRAIN_CYCLES = 250;
    localparam int STALL_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [5:0]         count;
        logic signed [7:0]  strongest;
        logic signed [11:0] mean;
        logic [10:0]        spread;
        logic [6:0]         occ;
        logic signed [15:0] peak;
        logic               seen;
    } snap_t;

    typedef struct {
        logic               op;
        logic [31:0]        key;
        logic signed [7:0]  rssi;
        logic [31:0]        now;
        bit                 typed;
        snap_t              typed_snap;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [63:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    presence_table_occupancy_stats_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // table model
    logic [31:0]       tbl_keys [DEPTH];
    logic signed [7:0] tbl_rssi [DEPTH];
    logic [31:0]       tbl_times[DEPTH];
    int unsigned       tbl_count;
    longint            peak_avg;
    logic signed [7:0] floor_cfg;
    logic [31:0]       lifetime_cfg;
    logic [7:0]        sat_cfg;

    snap_t pending_snaps[$];
    int mismatches = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void record_sighting(logic [31:0] key, logic signed [7:0] rssi,
                                            logic [31:0] now);
        if (rssi < floor_cfg) return;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_keys[i] == key) begin
                tbl_rssi[i] = rssi;
                tbl_times[i] = now;
                return;
            end
        end
        if (tbl_count < DEPTH) begin
            tbl_keys[tbl_count] = key;
            tbl_rssi[tbl_count] = rssi;
            tbl_times[tbl_count] = now;
            tbl_count++;
        end
    endfunction

    function automatic snap_t take_snapshot(logic [31:0] now);
        snap_t s;
        int unsigned kept, sat, held;
        longint sum, sumsq, strongest, v, q;
        logic [31:0] age;
        kept = 0;
        sum = 0;
        sumsq = 0;
        strongest = -100;
        for (int i = 0; i < tbl_count; i++) begin
            age = now - tbl_times[i];
            if (age < lifetime_cfg) begin
                tbl_keys[kept] = tbl_keys[i];
                tbl_rssi[kept] = tbl_rssi[i];
                tbl_times[kept] = tbl_times[i];
                kept++;
            end
        end
        tbl_count = kept;
        for (int i = 0; i < kept; i++) begin
            if (tbl_rssi[i] > strongest) strongest = tbl_rssi[i];
            sum += tbl_rssi[i];
            sumsq += longint'(tbl_rssi[i]) * tbl_rssi[i];
        end
        s.count = kept;
        s.strongest = strongest;
        if (kept > 0) begin
            q = (sum * 16) / longint'(kept);
            s.mean = q;
        end else begin
            s.mean = -1600;
        end
        s.spread = 0;
        if (kept > 1) begin
            v = longint'(kept) * sumsq - sum * sum;
            if (v < 0) v = 0;
            s.spread = int_sqrt((longint'(v) * 256) / (longint'(kept) * kept));
        end
        sat = (sat_cfg == 0) ? 1 : sat_cfg;
        held = (kept < sat) ? kept : sat;
        s.occ = (200 * held + sat) / (2 * sat);
        if (kept > 0)
            peak_avg = (7 * peak_avg + 768 * strongest + 5 + 655360) / 10 - 65536;
        s.peak = peak_avg;
        s.seen = (kept > 0);
        return s;
    endfunction

    task automatic send_item(logic op, logic [31:0] key, logic signed [7:0] rssi,
                             logic [31:0] now, bit typed, snap_t typed_snap);
        snap_t s;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {now, rssi, key};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_OBSERVE) begin
            record_sighting(key, rssi, now);
        end else begin
            s = take_snapshot(now);
            pending_snaps.push_back(typed ? typed_snap : s);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            CFG_RSSI_FLOOR: floor_cfg = val[7:0];
            CFG_LIFETIME:   lifetime_cfg = val;
            CFG_SAT_COUNT:  sat_cfg = val[7:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_tvalid <= 0;
        while (pending_snaps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // result check
    always @(posedge aclk) begin
        snap_t e, a;
        if (aresetn && m_tvalid && m_tready) begin
            a.count = m_tdata[5:0];
            a.strongest = m_tdata[13:6];
            a.mean = m_tdata[25:14];
            a.spread = m_tdata[36:26];
            a.occ = m_tdata[43:37];
            a.peak = m_tdata[59:44];
            a.seen = m_tdata[60];
            if (pending_snaps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                e = pending_snaps.pop_front();
                if (e != a) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp n=%0d max=%0d mean=%0d sd=%0d occ=%0d pk=%0d any=%0d",
                                 e.count, e.strongest, e.mean, e.spread, e.occ, e.peak, e.seen);
                        $display("         act n=%0d max=%0d mean=%0d sd=%0d occ=%0d pk=%0d any=%0d",
                                 a.count, a.strongest, a.mean, a.spread, a.occ, a.peak, a.seen);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic run_random(int items);
        logic [31:0] key_pool[40];
        logic [31:0] t, step, key, now;
        logic signed [7:0] rssi;
        logic op;
        snap_t none;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        t = ($urandom_range(3) == 0) ? 32'hFFFF_F000 + $urandom_range(4095) : $urandom;
        step = (lifetime_cfg == 0) ? 32'd100 : (lifetime_cfg >> 3) + 1;
        for (int n = 0; n < items; n++) begin
            op = ($urandom_range(7) == 0) ? OP_SNAPSHOT : OP_OBSERVE;
            key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(39)] : $urandom;
            if ($urandom_range(9) < 7)
                rssi = floor_cfg + $urandom_range(0, 127 - int'(floor_cfg));
            else
                rssi = $urandom;
            t = t + $urandom_range(0, step);
            now = ($urandom_range(49) == 0) ? $urandom : t;
            send_item(op, key, rssi, now, 0, none);
        end
    endtask

    initial begin
        row_t rows[$];
        row_t r;
        snap_t empty;
        empty = '{count: 0, strongest: -100, mean: -1600, spread: 0, occ: 0,
                  peak: -25600, seen: 0};
        tbl_count = 0;
        peak_avg = -25600;
        floor_cfg = -90;
        lifetime_cfg = 60000;
        sat_cfg = 10;
        r.typed = 0;
        r.typed_snap = empty;

        r.op = OP_SNAPSHOT; r.key = 0; r.rssi = 0; r.now = 0; r.typed = 1; rows.push_back(r);
        r.typed = 0;
        r.op = OP_OBSERVE; r.key = 0; r.rssi = -128; r.now = 10; rows.push_back(r);
        r.key = 32'hFFFF_FFFF; r.rssi = 127; r.now = 20; rows.push_back(r);
        r.key = 0; r.rssi = -90; r.now = 30; rows.push_back(r);
        r.key = 0; r.rssi = -91; r.now = 31; rows.push_back(r);
        r.key = 32'hA5A5_A5A5; r.rssi = -1; r.now = 40; rows.push_back(r);
        r.key = 32'hFFFF_FFFF; r.rssi = -50; r.now = 50; rows.push_back(r);
        r.op = OP_SNAPSHOT; r.now = 100; rows.push_back(r);
        r.now = 60049; rows.push_back(r);
        r.op = OP_OBSERVE; r.key = 32'h1234_5678; r.rssi = 0; r.now = 32'hFFFF_FFF0;
        rows.push_back(r);
        r.key = 32'h5A5A_5A5A; r.rssi = -89; r.now = 32'hFFFF_FFFF; rows.push_back(r);
        r.op = OP_SNAPSHOT; r.now = 10; rows.push_back(r);
        r.now = 32'h8000_0000; rows.push_back(r);
        r.now = 32'h8000_0001; r.typed = 0; rows.push_back(r);

        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        tx_idle_pct = 32; rx_idle_pct = 61;
        foreach (rows[i])
            send_item(rows[i].op, rows[i].key, rows[i].rssi, rows[i].now,
                      rows[i].typed, rows[i].typed_snap);
        run_random(200);

        settle();
        write_reg(CFG_RSSI_FLOOR, 32'hFFFF_FF80);
        write_reg(CFG_LIFETIME, 32'd1000);
        write_reg(CFG_SAT_COUNT, 32'd1);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        run_random(200);

        settle();
        write_reg(CFG_RSSI_FLOOR, 32'd127);
        write_reg(CFG_LIFETIME, 32'hFFFF_FFFF);
        write_reg(CFG_SAT_COUNT, 32'd255);
        run_random(180);

        settle();
        tx_idle_pct = 61; rx_idle_pct = 32;
        write_reg(CFG_RSSI_FLOOR, 32'hFFFF_FFC4);
        write_reg(CFG_LIFETIME, 32'd0);
        write_reg(CFG_SAT_COUNT, 32'd0);
        run_random(150);

        settle();
        write_reg(CFG_RSSI_FLOOR, 32'hFFFF_FFA6);
        write_reg(CFG_LIFETIME, 32'd500);
        write_reg(CFG_SAT_COUNT, 32'd5);
        run_random(200);

        settle();
        tx_idle_pct = 0; rx_idle_pct = 0;
        write_reg(CFG_RSSI_FLOOR, 32'd0);
        write_reg(CFG_LIFETIME, 32'd20000);
        write_reg(CFG_SAT_COUNT, 32'd32);
        run_random(200);

        settle();
        write_reg(CFG_RSSI_FLOOR, 32'hFFFF_FF9C);
        write_reg(CFG_LIFETIME, 32'd3000);
        write_reg(CFG_SAT_COUNT, 32'd10);
        run_random(200);

        settle();
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
